// File: sv/xoshiro128_range_generator_core_assert.svh
// Assertion helpers for the range generator; they expect clk and rst_n in scope.
`ifndef XOSHIRO128_RANGE_GENERATOR_CORE_ASSERT_SVH
`define XOSHIRO128_RANGE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define XRG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xrg assertion failed");

// Next-cycle implication, disabled while in reset.
`define XRG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xrg assertion failed");

`endif

// File: sv/xrg_pkg.sv
`default_nettype none

package xrg_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned SeedW  = 64;
  localparam int unsigned CntW   = $clog2(WordW);
  localparam int unsigned CfgIdxW = 1;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_RANGE_HIGH = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // SplitMix64 constants
  localparam logic [SeedW-1:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [SeedW-1:0] MIX_C1     = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [SeedW-1:0] MIX_C2     = 64'h94D0_49BB_1331_11EB;

  // fallback state words, entry 0 in the low slot
  localparam logic [3:0][WordW-1:0] FALLBACK = {
    32'h1234_5678, 32'hFEED_F00D, 32'hCAFE_BABE, 32'hDEAD_BEEF
  };

  typedef enum logic [1:0] {
    ACT_RESEED = 2'd0,
    ACT_RAW    = 2'd1,
    ACT_MOD    = 2'd2,
    ACT_UNB    = 2'd3
  } act_t;

  // partial product selection of the 64x64 low-half multiply
  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mph_t;

  typedef struct packed {
    act_t             action;
    logic [SeedW-1:0] seed_value;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]        word;
    logic signed [WordW-1:0] number;
    logic                    status;
  } out_item_t;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000_0000_0000_0001,
    S_DISP     = 15'b000_0000_0000_0010,
    S_XS1      = 15'b000_0000_0000_0100,
    S_MULA     = 15'b000_0000_0000_1000,
    S_XS2      = 15'b000_0000_0001_0000,
    S_MULB     = 15'b000_0000_0010_0000,
    S_STORE    = 15'b000_0000_0100_0000,
    S_CHECK    = 15'b000_0000_1000_0000,
    S_DRAW     = 15'b000_0001_0000_0000,
    S_TEST     = 15'b000_0010_0000_0000,
    S_THR_GO   = 15'b000_0100_0000_0000,
    S_THR_WAIT = 15'b000_1000_0000_0000,
    S_REM_GO   = 15'b001_0000_0000_0000,
    S_REM_WAIT = 15'b010_0000_0000_0000,
    S_DONE     = 15'b100_0000_0000_0000
  } state_t;

  typedef struct packed {
    logic accept;      // latch item and range snapshot
    logic mix_xs1;     // z = acc ^ (acc >> 30)
    logic mix_xs2;     // z = prod ^ (prod >> 27)
    logic mul_en;
    mph_t mul_ph;
    logic mul_c2;      // second mix constant
    logic store_en;    // write finished mix into a state half
    logic store_half;
    logic chk_zero;    // replace all-zero state by fallback
    logic draw;        // advance generator, latch word
    logic div_start;
    logic div_thr;     // divide the rejection threshold dividend
    logic thr_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic gt;          // low exceeds high
    logic eq;          // low equals high
    logic span_zero;   // span covers the whole 32-bit range
    logic below_thr;   // last word falls in the rejected zone
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/xoshiro128_range_generator_core.sv
// xoshiro128** generator with integer range draws.
// Input channel (in_valid / in_stall / in_data): one item carries an action
// and a 64-bit seed. Actions: reseed, raw draw, modulo range draw, unbiased
// range draw. Every item yields exactly one result item on the output channel
// (out_valid / out_stall / out_data: word, signed number, status).
// Configuration: write range_low (index 0) and range_high (index 1) through
// cfg_we / cfg_index / cfg_data while no item is in flight.
// Processing steps per action: a raw draw advances the generator once; reseed
// runs two SplitMix64 rounds, each multiply split into three 32x32 partial
// products on one shared multiplier; a modulo draw uses the 32-step radix-2
// remainder unit; an unbiased draw runs the threshold remainder, then the draw
// loop (one more draw per rejected word), then the final remainder. Full-range
// draws skip the remainder; refused and equal-end unbiased draws skip the
// generator. One item is worked on at a time; the next item can be taken in
// the same cycle that the result first sits in the output register.
// Reset (rst_n low, synchronous): state words load the fallback words, both
// range ends clear to zero, no result is pending.
// Output stall: the result holds in the output register; a following finished
// result waits inside the block until that register drains.
`default_nettype none

module xoshiro128_range_generator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire xrg_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output xrg_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [xrg_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [xrg_pkg::WordW-1:0]     cfg_data
);

  xrg_pkg::cmd_t cmd;
  xrg_pkg::sts_t sts;

  // sequencer: action dispatch, multiply phases, divider handshake, output hold
  xrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // generator state, range registers, mix multiplier, remainder unit, result
  xrg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_data)
  );

endmodule

`default_nettype wire

// File: sv/xrg_rem.sv
`default_nettype none

module xrg_rem (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [xrg_pkg::WordW-1:0]  dividend,
  input  wire logic [xrg_pkg::WordW-1:0]  divisor,
  output logic                            done,
  output logic [xrg_pkg::WordW-1:0]       rem
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [xrg_pkg::CntW-1:0]     cnt_r, cnt_nxt;
  logic [xrg_pkg::WordW-1:0]    rem_r, rem_nxt;
  logic [xrg_pkg::WordW-1:0]    dvd_r, dvd_nxt;
  logic [xrg_pkg::WordW-1:0]    div_r, div_nxt;
  logic [xrg_pkg::WordW:0]      trial;

  // restoring radix-2 step: one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    trial    = {rem_r, dvd_r[xrg_pkg::WordW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = xrg_pkg::CntW'(xrg_pkg::WordW - 1);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = xrg_pkg::WordW'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[xrg_pkg::WordW-1:0];
      end
      dvd_nxt = {dvd_r[xrg_pkg::WordW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: sv/xrg_dp.sv
`default_nettype none

module xrg_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire xrg_pkg::in_item_t             in_item,
  input  wire logic                          cfg_we,
  input  wire logic [xrg_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [xrg_pkg::WordW-1:0]     cfg_data,
  input  wire xrg_pkg::cmd_t                 cmd,
  output xrg_pkg::sts_t                      sts,
  output xrg_pkg::out_item_t                 out_item
);

  localparam int unsigned W = xrg_pkg::WordW;

  logic [3:0][W-1:0]              gw_r, gw_nxt;
  logic [W-1:0]                   lo_r, hi_r;
  xrg_pkg::act_t                  act_r;
  logic                           gt_r, eq_r, spz_r;
  logic [W-1:0]                   base_r, span_r;
  logic [xrg_pkg::SeedW-1:0]      acc_r, z_r, prod_r;
  logic [W-1:0]                   word_r, thr_r;
  xrg_pkg::out_item_t             out_r, res;

  logic                           gt_in;
  logic [W-1:0]                   lo_s, hi_s, span_in;
  logic [W-1:0]                   m5, rot, gen_out, t9;
  logic [W-1:0]                   n0, n1, n2, n3;
  logic [xrg_pkg::SeedW-1:0]      mconst, mixv;
  logic [W-1:0]                   mul_a, mul_b;
  logic [xrg_pkg::SeedW-1:0]      mul_p;
  logic [W-1:0]                   div_dvd, rem;
  logic                           div_done;

  // swap reversed ends; the unbiased draw refuses them instead
  assign gt_in   = $signed(lo_r) > $signed(hi_r);
  assign lo_s    = gt_in ? hi_r : lo_r;
  assign hi_s    = gt_in ? lo_r : hi_r;
  assign span_in = hi_s - lo_s + 1'b1;

  // xoshiro128** output and state step
  assign m5      = gw_r[1] + {gw_r[1][W-3:0], 2'b00};
  assign rot     = {m5[W-8:0], m5[W-1:W-7]};
  assign gen_out = rot + {rot[W-4:0], 3'b000};
  assign t9      = {gw_r[1][W-10:0], 9'd0};
  assign n2      = gw_r[2] ^ gw_r[0];
  assign n3      = gw_r[3] ^ gw_r[1];
  assign n1      = gw_r[1] ^ n2;
  assign n0      = gw_r[0] ^ n3;

  // low 64 bits of z * const from three 32x32 partial products
  assign mconst = cmd.mul_c2 ? xrg_pkg::MIX_C2 : xrg_pkg::MIX_C1;
  assign mul_a  = (cmd.mul_ph == xrg_pkg::MUL_HL) ? z_r[2*W-1:W] : z_r[W-1:0];
  assign mul_b  = (cmd.mul_ph == xrg_pkg::MUL_LH) ? mconst[2*W-1:W] : mconst[W-1:0];
  assign mul_p  = mul_a * mul_b;
  assign mixv   = prod_r ^ (prod_r >> 31);

  assign div_dvd = cmd.div_thr ? (32'd0 - span_r) : word_r;

  xrg_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (span_r),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    gw_nxt = gw_r;
    if (cmd.draw) begin
      gw_nxt[0] = n0;
      gw_nxt[1] = n1;
      gw_nxt[2] = n2 ^ t9;
      gw_nxt[3] = {n3[W-12:0], n3[W-1:W-11]};
    end else if (cmd.store_en) begin
      if (cmd.store_half) begin
        gw_nxt[2] = mixv[W-1:0];
        gw_nxt[3] = mixv[2*W-1:W];
      end else begin
        gw_nxt[0] = mixv[W-1:0];
        gw_nxt[1] = mixv[2*W-1:W];
      end
    end else if (cmd.chk_zero) begin
      if ((gw_r[0] | gw_r[1] | gw_r[2] | gw_r[3]) == '0) begin
        gw_nxt = xrg_pkg::FALLBACK;
      end
    end
  end

  // result assembly from the latched action and range flags
  always_comb begin
    res        = '0;
    res.status = xrg_pkg::STATUS_OK;
    unique case (act_r)
      xrg_pkg::ACT_RESEED: begin
        res.word = '0;
      end
      xrg_pkg::ACT_RAW: begin
        res.word = word_r;
      end
      xrg_pkg::ACT_MOD: begin
        res.word   = word_r;
        res.number = spz_r ? word_r : base_r + rem;
      end
      xrg_pkg::ACT_UNB: begin
        priority if (gt_r) begin
          res.status = xrg_pkg::STATUS_REFUSED;
        end else if (eq_r) begin
          res.number = base_r;
        end else if (spz_r) begin
          res.word   = word_r;
          res.number = base_r + word_r;
        end else begin
          res.word   = word_r;
          res.number = base_r + rem;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= xrg_pkg::FALLBACK;
      lo_r <= '0;
      hi_r <= '0;
    end else begin
      gw_r <= gw_nxt;
      if (cfg_we && cfg_index == xrg_pkg::REG_RANGE_LOW) begin
        lo_r <= cfg_data;
      end
      if (cfg_we && cfg_index == xrg_pkg::REG_RANGE_HIGH) begin
        hi_r <= cfg_data;
      end
    end
    if (cmd.accept) begin
      act_r  <= in_item.action;
      gt_r   <= gt_in;
      eq_r   <= (lo_r == hi_r);
      spz_r  <= (span_in == '0);
      base_r <= lo_s;
      span_r <= span_in;
      acc_r  <= in_item.seed_value + xrg_pkg::MIX_GOLDEN;
    end else if (cmd.store_en && !cmd.store_half) begin
      acc_r <= acc_r + xrg_pkg::MIX_GOLDEN;
    end
    if (cmd.mix_xs1) begin
      z_r <= acc_r ^ (acc_r >> 30);
    end else if (cmd.mix_xs2) begin
      z_r <= prod_r ^ (prod_r >> 27);
    end
    if (cmd.mul_en) begin
      if (cmd.mul_ph == xrg_pkg::MUL_LL) begin
        prod_r <= mul_p;
      end else begin
        prod_r[2*W-1:W] <= prod_r[2*W-1:W] + mul_p[W-1:0];
      end
    end
    if (cmd.draw) begin
      word_r <= gen_out;
    end
    if (cmd.thr_load) begin
      thr_r <= rem;
    end
    if (cmd.out_load) begin
      out_r <= res;
    end
  end

  always_comb begin
    sts           = '0;
    sts.act       = act_r;
    sts.gt        = gt_r;
    sts.eq        = eq_r;
    sts.span_zero = spz_r;
    sts.below_thr = (word_r < thr_r);
    sts.div_done  = div_done;
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// File: sv/xrg_ctrl.sv
`default_nettype none

module xrg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire xrg_pkg::sts_t   sts,
  output xrg_pkg::cmd_t        cmd
);

  xrg_pkg::state_t state_r, state_nxt;
  xrg_pkg::mph_t   ph_r, ph_nxt;
  logic            half_r, half_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ph_nxt    = ph_r;
    half_nxt  = half_r;
    unique case (state_r)
      xrg_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = xrg_pkg::S_DISP;
        end
      end
      xrg_pkg::S_DISP: begin
        unique case (sts.act)
          xrg_pkg::ACT_RESEED: begin
            half_nxt  = 1'b0;
            state_nxt = xrg_pkg::S_XS1;
          end
          xrg_pkg::ACT_RAW, xrg_pkg::ACT_MOD: begin
            state_nxt = xrg_pkg::S_DRAW;
          end
          xrg_pkg::ACT_UNB: begin
            priority if (sts.gt || sts.eq) begin
              state_nxt = xrg_pkg::S_DONE;
            end else if (sts.span_zero) begin
              state_nxt = xrg_pkg::S_DRAW;
            end else begin
              state_nxt = xrg_pkg::S_THR_GO;
            end
          end
          default: state_nxt = xrg_pkg::S_DONE;
        endcase
      end
      xrg_pkg::S_XS1: begin
        cmd.mix_xs1 = 1'b1;
        ph_nxt      = xrg_pkg::MUL_LL;
        state_nxt   = xrg_pkg::S_MULA;
      end
      xrg_pkg::S_MULA, xrg_pkg::S_MULB: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ph = ph_r;
        cmd.mul_c2 = (state_r == xrg_pkg::S_MULB);
        unique case (ph_r)
          xrg_pkg::MUL_LL: ph_nxt = xrg_pkg::MUL_LH;
          xrg_pkg::MUL_LH: ph_nxt = xrg_pkg::MUL_HL;
          xrg_pkg::MUL_HL: begin
            ph_nxt    = xrg_pkg::MUL_LL;
            state_nxt = (state_r == xrg_pkg::S_MULB) ? xrg_pkg::S_STORE : xrg_pkg::S_XS2;
          end
          default: ph_nxt = xrg_pkg::MUL_LL;
        endcase
      end
      xrg_pkg::S_XS2: begin
        cmd.mix_xs2 = 1'b1;
        ph_nxt      = xrg_pkg::MUL_LL;
        state_nxt   = xrg_pkg::S_MULB;
      end
      xrg_pkg::S_STORE: begin
        cmd.store_en   = 1'b1;
        cmd.store_half = half_r;
        if (!half_r) begin
          half_nxt  = 1'b1;
          state_nxt = xrg_pkg::S_XS1;
        end else begin
          state_nxt = xrg_pkg::S_CHECK;
        end
      end
      xrg_pkg::S_CHECK: begin
        cmd.chk_zero = 1'b1;
        state_nxt    = xrg_pkg::S_DONE;
      end
      xrg_pkg::S_DRAW: begin
        cmd.draw = 1'b1;
        unique case (sts.act)
          xrg_pkg::ACT_MOD:
            state_nxt = sts.span_zero ? xrg_pkg::S_DONE : xrg_pkg::S_REM_GO;
          xrg_pkg::ACT_UNB:
            state_nxt = sts.span_zero ? xrg_pkg::S_DONE : xrg_pkg::S_TEST;
          default:
            state_nxt = xrg_pkg::S_DONE;
        endcase
      end
      xrg_pkg::S_TEST: begin
        state_nxt = sts.below_thr ? xrg_pkg::S_DRAW : xrg_pkg::S_REM_GO;
      end
      xrg_pkg::S_THR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_thr   = 1'b1;
        state_nxt     = xrg_pkg::S_THR_WAIT;
      end
      xrg_pkg::S_THR_WAIT: begin
        cmd.div_thr = 1'b1;
        if (sts.div_done) begin
          cmd.thr_load = 1'b1;
          state_nxt    = xrg_pkg::S_DRAW;
        end
      end
      xrg_pkg::S_REM_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = xrg_pkg::S_REM_WAIT;
      end
      xrg_pkg::S_REM_WAIT: begin
        if (sts.div_done) begin
          state_nxt = xrg_pkg::S_DONE;
        end
      end
      xrg_pkg::S_DONE: begin
        // hold the result here until the output register frees up
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = xrg_pkg::S_IDLE;
        end
      end
      default: state_nxt = xrg_pkg::S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xrg_pkg::S_IDLE;
      ph_r        <= xrg_pkg::MUL_LL;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != xrg_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: sv/xrg_chk.sv
`default_nettype none
`include "xoshiro128_range_generator_core_assert.svh"

module xrg_chk (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire xrg_pkg::out_item_t            out_data
);

  // a stalled result stays put
  `XRG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // after taking an item the block is busy with it
  `XRG_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a refused draw carries no word and no number
  `XRG_ASSERT_IMP(a_refused_empty,
    out_valid && out_data.status == xrg_pkg::STATUS_REFUSED,
    out_data.word == '0 && out_data.number == '0)

  // a result only appears after an item was taken
  `XRG_ASSERT_NXT(a_no_spurious_out, !out_valid && in_stall == 1'b0 && !in_valid,
    !out_valid)

endmodule

bind xoshiro128_range_generator_core xrg_chk u_chk (.*);

`default_nettype wire
